// ===== hdl/kts_pkg.sv =====
// Shared types, codes and constants of the keyframe track sampler.
package kts_pkg;

  localparam int MAX_KEYS_DEF  = 256;
  localparam int MAX_WIDTH_DEF = 8;
  localparam int RESULT_LIMIT  = 8;
  localparam int VEC_COMPS     = 3;
  localparam int QUAT_COMPS    = 4;

  // Divider geometry: 48-bit dividend, 32-bit divisor.
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;

  localparam logic [1:0] KIND_TIME   = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] CH_TRANSLATION = 2'd0;
  localparam logic [1:0] CH_SCALE       = 2'd1;
  localparam logic [1:0] CH_ROTATION    = 2'd2;
  localparam logic [1:0] CH_MORPH       = 2'd3;

  localparam logic INTERP_STEP   = 1'b0;
  localparam logic INTERP_LINEAR = 1'b1;
  localparam logic PLAY_CLAMP    = 1'b0;
  localparam logic PLAY_LOOP     = 1'b1;

  localparam logic [2:0] REG_CHANNEL_KIND  = 3'd0;
  localparam logic [2:0] REG_MORPH_COUNT   = 3'd1;
  localparam logic [2:0] REG_INTERP_MODE   = 3'd2;
  localparam logic [2:0] REG_KEY_COUNT     = 3'd3;
  localparam logic [2:0] REG_PLAYBACK_MODE = 3'd4;
  localparam logic [2:0] REG_CLIP_DURATION = 3'd5;
  localparam logic [2:0] REG_RANGE_START   = 3'd6;
  localparam logic [2:0] REG_RANGE_END     = 3'd7;

  typedef struct packed {
    logic [1:0]  channel_kind;
    logic [3:0]  morph_weight_count;
    logic        interpolation_mode;
    logic [8:0]  key_count;
    logic        playback_mode;
    logic [31:0] clip_duration;
    logic [31:0] range_start;
    logic [31:0] range_end;
  } cfg_t;

  // One classified word passed from the front to the back.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  key;
    logic [2:0]  comp;
    logic [31:0] data;
  } item_t;

endpackage

// ===== hdl/kts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/kts_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module kts_div import kts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quotient,
  output logic [DIV_DW-1:0] remainder
);

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] dvd;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_DW-1:0] rem;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;

  assign rem_sh    = {rem, dvd[DIV_NW-1]};
  assign ge        = rem_sh >= {1'b0, dsr};
  assign quotient  = dvd;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= CW'(DIV_NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? DIV_DW'(rem_sh - {1'b0, dsr}) : DIV_DW'(rem_sh);
        dvd <= {dvd[DIV_NW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/kts_isqrt.sv =====
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
module kts_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [35:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign rem_sh = {rem[33:0], rad[63:62]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= 6'd32;
        busy <= 1'b1;
      end else if (busy) begin
        rad <= {rad[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/kts_front.sv =====
// Input side: accept words, drop the ones that do nothing, queue the rest.
module kts_front import kts_pkg::*; #(
  parameter int MAX_KEYS  = MAX_KEYS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  key_index,
  input  logic [2:0]  component_index,
  input  logic [31:0] key_time,
  input  logic [31:0] key_value,
  input  logic [31:0] request_time,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       keep;
  logic       push;
  item_t      word;

  always_comb begin
    word.kind = kind;
    word.key  = key_index;
    word.comp = component_index;
    unique case (kind)
      KIND_TIME: begin
        word.data = key_time;
        keep      = 32'(key_index) < 32'(MAX_KEYS);
      end
      KIND_VALUE: begin
        word.data = key_value;
        keep      = (32'(key_index) < 32'(MAX_KEYS)) &&
                    (32'(component_index) < 32'(MAX_WIDTH));
      end
      KIND_SAMPLE: begin
        word.data = request_time;
        keep      = 1'b1;
      end
      default: begin
        word.data = request_time;
        keep      = 1'b0;
      end
    endcase
  end

  assign in_ready = count != 2'd2;
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = count != 2'd0;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hdl/kts_back.sv =====
// Execution side: key stores, time mapping, key search, interpolation, output register.
module kts_back import kts_pkg::*; #(
  parameter int MAX_KEYS  = MAX_KEYS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_component,
  output logic [31:0] out_value,
  output logic [31:0] used_time,
  output logic        status,
  output logic        last
);

  localparam int KW  = $clog2(MAX_KEYS);
  localparam int NW  = $clog2(MAX_KEYS + 1);
  localparam int VAW = $clog2(MAX_KEYS * MAX_WIDTH);

  localparam logic [4:0] S_IDLE = 5'd0,  S_ERR = 5'd1,  S_MAP = 5'd2,  S_MODW = 5'd3;
  localparam logic [4:0] S_K0   = 5'd4,  S_K0C = 5'd5,  S_KN  = 5'd6,  S_KNC  = 5'd7;
  localparam logic [4:0] S_BS   = 5'd8,  S_BSC = 5'd9,  S_TL  = 5'd10, S_TR   = 5'd11;
  localparam logic [4:0] S_TRC  = 5'd12, S_FW  = 5'd13, S_HOLD = 5'd14, S_HP  = 5'd15;
  localparam logic [4:0] S_LA   = 5'd16, S_LB  = 5'd17, S_LM  = 5'd18, S_LP   = 5'd19;
  localparam logic [4:0] S_QA   = 5'd20, S_QB  = 5'd21, S_QC  = 5'd22, S_QD   = 5'd23;
  localparam logic [4:0] S_QL   = 5'd24, S_QV  = 5'd25, S_QS  = 5'd26, S_QT   = 5'd27;
  localparam logic [4:0] S_QR   = 5'd28, S_QN  = 5'd29, S_QW  = 5'd30, S_QP   = 5'd31;

  function automatic logic [VAW-1:0] vaddr(input logic [KW-1:0] k, input logic [2:0] cc);
    return VAW'(32'(k) * 32'(MAX_WIDTH) + 32'(cc));
  endfunction

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -38'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  logic [4:0]          state;
  logic signed [31:0]  treq;
  logic                dneg;
  logic [31:0]         ut;
  logic [NW-1:0]       lo, hi, mid_r;
  logic [KW-1:0]       kleft, kright;
  logic [31:0]         tl;
  logic [16:0]         f;
  logic [2:0]          c;
  logic signed [31:0]  a_reg;
  logic signed [51:0]  lprod;
  logic signed [63:0]  mprod;
  logic signed [63:0]  dot;
  logic [63:0]         ssum;
  logic signed [31:0]  qa [4];
  logic signed [31:0]  qb [4];
  logic signed [32:0]  qv [4];
  logic [31:0]         qo;

  logic          t_we, v_we;
  logic [KW-1:0] t_raddr;
  logic [VAW-1:0] v_raddr;
  logic [31:0]   t_rdata, v_rdata;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_dvd, div_quo;
  logic [DIV_DW-1:0] div_dsr, div_rem;
  logic              sq_start, sq_done;
  logic [31:0]       sq_root;

  logic [31:0]        end_v, span;
  logic               zd, range_bad;
  logic [NW-1:0]      n_keys, mid, rsel;
  logic [3:0]         n_comp;
  logic               go_rot, last_c, frac_ok, slot_free, put_en;
  logic [1:0]         ci;
  logic signed [33:0] d, tsx;
  logic [33:0]        dmag;
  logic [31:0]        clamp_t, mod_m, m_rem;
  logic signed [33:0] lerp_a, lerp_b;
  logic signed [51:0] lerp_prod;
  logic signed [37:0] v_full;
  logic signed [32:0] mul_x, mul_y;
  logic signed [63:0] mul_p;
  logic [64:0]        ssum_add;
  logic [63:0]        ssum_next;
  logic [31:0]        qmag, norm;
  logic [3:0]         mw;
  logic [2:0]         p_comp;
  logic [31:0]        p_val, p_time;
  logic               p_status, p_last;

  assign ci = c[1:0];

  // Derived cfg values; the user keeps them stable while a sample runs, unenforced.
  assign end_v     = (cfg.range_end == 32'd0) ? cfg.clip_duration : cfg.range_end;
  assign span      = end_v - cfg.range_start;
  assign zd        = (cfg.clip_duration == 32'd0) && (cfg.range_start == 32'd0) &&
                     (cfg.range_end == 32'd0);
  assign range_bad = ((end_v <= cfg.range_start) || (end_v > cfg.clip_duration)) && !zd;
  assign go_rot    = cfg.channel_kind == CH_ROTATION;

  always_comb begin
    if (cfg.key_count == 9'd0) begin
      n_keys = NW'(1);
    end else if (32'(cfg.key_count) > 32'(MAX_KEYS)) begin
      n_keys = NW'(MAX_KEYS);
    end else begin
      n_keys = NW'(cfg.key_count);
    end
  end

  always_comb begin
    mw = (cfg.morph_weight_count == 4'd0) ? 4'd1 : cfg.morph_weight_count;
    if (32'(mw) > 32'(MAX_WIDTH)) begin
      mw = 4'(MAX_WIDTH);
    end
    if (32'(mw) > 32'(RESULT_LIMIT)) begin
      mw = 4'(RESULT_LIMIT);
    end
    if (cfg.channel_kind == CH_ROTATION) begin
      n_comp = 4'(QUAT_COMPS);
    end else if (cfg.channel_kind == CH_MORPH) begin
      n_comp = mw;
    end else begin
      n_comp = 4'(VEC_COMPS);
    end
  end

  assign last_c = {1'b0, c} == n_comp - 4'd1;

  // Time mapping.
  assign tsx  = 34'(treq);
  assign d    = tsx - $signed({2'b00, cfg.range_start});
  assign dmag = d[33] ? 34'(-d) : 34'(d);

  always_comb begin
    if (tsx < $signed({2'b00, cfg.range_start})) begin
      clamp_t = cfg.range_start;
    end else if (tsx > $signed({2'b00, end_v})) begin
      clamp_t = end_v;
    end else begin
      clamp_t = treq;
    end
  end

  assign m_rem = div_rem;
  assign mod_m = (dneg && (m_rem != 32'd0)) ? span - m_rem : m_rem;

  // Search.
  assign mid = lo + ((hi - lo) >> 1);

  always_comb begin
    rsel = lo;
    if (rsel == NW'(0)) begin
      rsel = NW'(1);
    end
    if (rsel > n_keys - NW'(1)) begin
      rsel = n_keys - NW'(1);
    end
  end

  assign frac_ok = (t_rdata > tl) && (ut > tl);

  // Arithmetic shared by the linear and rotation paths.
  always_comb begin
    if (state == S_QL) begin
      lerp_a = 34'(qa[ci]);
      lerp_b = dot[63] ? -34'(qb[ci]) : 34'(qb[ci]);
    end else begin
      lerp_a = 34'(a_reg);
      lerp_b = 34'($signed(v_rdata));
    end
  end

  assign lerp_prod = 52'((lerp_b - lerp_a) * $signed({1'b0, f}));
  assign v_full    = 38'(a_reg) + 38'((lprod + 52'sd32768) >>> 16);

  always_comb begin
    if (state == S_QC) begin
      mul_x = 33'(qa[ci]);
      mul_y = 33'($signed(v_rdata));
    end else begin
      mul_x = qv[ci];
      mul_y = qv[ci];
    end
  end

  assign mul_p     = 64'(mul_x * mul_y);
  assign ssum_add  = {1'b0, ssum} + {1'b0, mprod};
  assign ssum_next = ssum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : ssum_add[63:0];

  assign qmag = qv[ci][32] ? 32'(-qv[ci]) : 32'(qv[ci]);

  always_comb begin
    if (qv[ci][32]) begin
      norm = (div_quo > 48'h0000_8000_0000) ? 32'h8000_0000 : -div_quo[31:0];
    end else begin
      norm = (div_quo > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
    end
  end

  // Divider and root unit requests.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    unique case (state)
      S_MAP: begin
        div_start = (cfg.playback_mode == PLAY_LOOP) && !zd;
        div_dvd   = DIV_NW'(dmag);
        div_dsr   = span;
      end
      S_TRC: begin
        div_start = frac_ok;
        div_dvd   = {ut - tl, 16'h0000};
        div_dsr   = t_rdata - tl;
      end
      S_QN: begin
        div_start = sq_root != 32'd0;
        div_dvd   = DIV_NW'({qmag, 16'h0000}) + DIV_NW'(sq_root >> 1);
        div_dsr   = sq_root;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign sq_start = (state == S_QT) && (ci == 2'd3);

  // Store accesses.
  assign q_pop = (state == S_IDLE) && q_valid;
  assign t_we  = q_pop && (q_item.kind == KIND_TIME);
  assign v_we  = q_pop && (q_item.kind == KIND_VALUE);

  always_comb begin
    unique case (state)
      S_K0:    t_raddr = '0;
      S_KN:    t_raddr = KW'(n_keys - NW'(1));
      S_BS:    t_raddr = KW'(mid);
      S_TL:    t_raddr = kleft;
      S_TR:    t_raddr = kright;
      default: t_raddr = '0;
    endcase
  end

  assign v_raddr = ((state == S_LB) || (state == S_QB)) ? vaddr(kright, c) : vaddr(kleft, c);

  kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
    .clk   (clk),
    .we    (t_we),
    .waddr (KW'(q_item.key)),
    .wdata (q_item.data),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS * MAX_WIDTH)) u_values (
    .clk   (clk),
    .we    (v_we),
    .waddr (vaddr(KW'(q_item.key), q_item.comp)),
    .wdata (q_item.data),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  kts_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  kts_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (ssum_next),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Output word.
  assign slot_free = !out_valid || out_ready;
  assign put_en    = slot_free && ((state == S_ERR) || (state == S_HP) ||
                                   (state == S_LP) || (state == S_QP));

  always_comb begin
    p_comp   = c;
    p_time   = ut;
    p_status = 1'b0;
    p_last   = last_c;
    unique case (state)
      S_ERR: begin
        p_comp   = 3'd0;
        p_val    = 32'd0;
        p_time   = 32'd0;
        p_status = 1'b1;
        p_last   = 1'b1;
      end
      S_HP:    p_val = v_rdata;
      S_LP:    p_val = sat32(v_full);
      default: p_val = qo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      out_component <= p_comp;
      out_value     <= p_val;
      used_time     <= p_time;
      status        <= p_status;
      last          <= p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (put_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && (q_item.kind == KIND_SAMPLE)) begin
            treq  <= $signed(q_item.data);
            state <= range_bad ? S_ERR : S_MAP;
          end
        end
        S_ERR: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        S_MAP: begin
          dneg <= d[33];
          if (cfg.playback_mode != PLAY_LOOP) begin
            ut    <= clamp_t;
            state <= S_K0;
          end else if (zd) begin
            ut    <= 32'd0;
            state <= S_K0;
          end else begin
            state <= S_MODW;
          end
        end
        S_MODW: begin
          if (div_done) begin
            ut    <= mod_m + cfg.range_start;
            state <= S_K0;
          end
        end
        S_K0: state <= S_K0C;
        S_K0C: begin
          if ((n_keys == NW'(1)) || (ut <= t_rdata)) begin
            kleft <= '0;
            c     <= 3'd0;
            state <= S_HOLD;
          end else begin
            state <= S_KN;
          end
        end
        S_KN: state <= S_KNC;
        S_KNC: begin
          if (ut >= t_rdata) begin
            kleft <= KW'(n_keys - NW'(1));
            c     <= 3'd0;
            state <= S_HOLD;
          end else begin
            lo    <= '0;
            hi    <= n_keys;
            state <= S_BS;
          end
        end
        S_BS: begin
          if (lo < hi) begin
            mid_r <= mid;
            state <= S_BSC;
          end else begin
            kleft  <= KW'(rsel - NW'(1));
            kright <= KW'(rsel);
            c      <= 3'd0;
            state  <= (cfg.interpolation_mode == INTERP_STEP) ? S_HOLD : S_TL;
          end
        end
        S_BSC: begin
          if (t_rdata <= ut) begin
            lo <= mid_r + NW'(1);
          end else begin
            hi <= mid_r;
          end
          state <= S_BS;
        end
        S_TL: state <= S_TR;
        S_TR: begin
          tl    <= t_rdata;
          state <= S_TRC;
        end
        S_TRC: begin
          if (frac_ok) begin
            state <= S_FW;
          end else begin
            f     <= 17'd0;
            c     <= 3'd0;
            dot   <= '0;
            ssum  <= '0;
            state <= go_rot ? S_QA : S_LA;
          end
        end
        S_FW: begin
          if (div_done) begin
            f     <= (div_quo > 48'd65536) ? 17'h10000 : div_quo[16:0];
            c     <= 3'd0;
            dot   <= '0;
            ssum  <= '0;
            state <= go_rot ? S_QA : S_LA;
          end
        end
        S_HOLD: state <= S_HP;
        S_HP: begin
          if (slot_free) begin
            c     <= c + 3'd1;
            state <= last_c ? S_IDLE : S_HOLD;
          end
        end
        S_LA: state <= S_LB;
        S_LB: begin
          a_reg <= $signed(v_rdata);
          state <= S_LM;
        end
        S_LM: begin
          lprod <= lerp_prod;
          state <= S_LP;
        end
        S_LP: begin
          if (slot_free) begin
            c     <= c + 3'd1;
            state <= last_c ? S_IDLE : S_LA;
          end
        end
        S_QA: state <= S_QB;
        S_QB: begin
          qa[ci] <= $signed(v_rdata);
          state  <= S_QC;
        end
        S_QC: begin
          qb[ci] <= $signed(v_rdata);
          mprod  <= mul_p;
          state  <= S_QD;
        end
        S_QD: begin
          dot <= dot + (mprod >>> 2);
          if (ci == 2'd3) begin
            c     <= 3'd0;
            state <= S_QL;
          end else begin
            c     <= c + 3'd1;
            state <= S_QA;
          end
        end
        S_QL: begin
          lprod <= lerp_prod;
          a_reg <= qa[ci];
          state <= S_QV;
        end
        S_QV: begin
          qv[ci] <= 33'(v_full);
          state  <= S_QS;
        end
        S_QS: begin
          mprod <= mul_p;
          state <= S_QT;
        end
        S_QT: begin
          ssum <= ssum_next;
          if (ci == 2'd3) begin
            c     <= 3'd0;
            state <= S_QR;
          end else begin
            c     <= c + 3'd1;
            state <= S_QL;
          end
        end
        S_QR: begin
          if (sq_done) begin
            state <= S_QN;
          end
        end
        S_QN: begin
          if (sq_root == 32'd0) begin
            qo    <= 32'd0;
            state <= S_QP;
          end else begin
            state <= S_QW;
          end
        end
        S_QW: begin
          if (div_done) begin
            qo    <= norm;
            state <= S_QP;
          end
        end
        S_QP: begin
          if (slot_free) begin
            c     <= c + 3'd1;
            state <= last_c ? S_IDLE : S_QN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/keyframe_track_sampler_unit.sv =====
// Top level of the keyframe track sampler: configuration registers, front and back.
//
// Holds one animation track (key times and up to MAX_WIDTH signed Q16.16
// components per key) and samples it. Words of kind 0 and 1 load a key time or
// a key component; kind 3 and out-of-range loads are accepted and dropped. A
// load is written in the back in the same cycle it leaves the two-word queue,
// so loads stream at one word per cycle while the back is idle. A sample
// request (kind 2) maps its time into the playback range (clamp, or loop
// through a modulo), finds the bracketing keys with a binary search over the
// key-time RAM, and emits one output word per component: held keys or step
// mode emit one key's values, linear mode interpolates between the two keys,
// rotation tracks do a hemisphere-corrected nlerp followed by normalization.
// All divisions (loop modulo, interpolation fraction and the normalization of
// each rotation component) share one radix-2 divider; a rotation sample also
// forms a dot product, lerps and squares, and an integer square root. A range
// that is invalid (end at or below start, or past the clip) gives a single
// word with status set. The output word sits in a register, so the next
// request is taken while a result still waits. Configuration is written
// through cfg_write/cfg_index/cfg_data and must only change while the block
// is idle.
module keyframe_track_sampler_unit import kts_pkg::*; #(
  parameter int MAX_KEYS  = MAX_KEYS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  key_index,
  input  logic [2:0]  component_index,
  input  logic [31:0] key_time,
  input  logic [31:0] key_value,
  input  logic [31:0] request_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_component,
  output logic [31:0] out_value,
  output logic [31:0] used_time,
  output logic        status,
  output logic        last
);

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // Register file: take each write at once, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_kind       <= 2'd0;
      cfg.morph_weight_count <= 4'd1;
      cfg.interpolation_mode <= 1'b1;
      cfg.key_count          <= 9'd1;
      cfg.playback_mode      <= 1'b0;
      cfg.clip_duration      <= 32'd0;
      cfg.range_start        <= 32'd0;
      cfg.range_end          <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHANNEL_KIND:  cfg.channel_kind       <= cfg_data[1:0];
        REG_MORPH_COUNT:   cfg.morph_weight_count <= cfg_data[3:0];
        REG_INTERP_MODE:   cfg.interpolation_mode <= cfg_data[0];
        REG_KEY_COUNT:     cfg.key_count          <= cfg_data[8:0];
        REG_PLAYBACK_MODE: cfg.playback_mode      <= cfg_data[0];
        REG_CLIP_DURATION: cfg.clip_duration      <= cfg_data;
        REG_RANGE_START:   cfg.range_start        <= cfg_data;
        REG_RANGE_END:     cfg.range_end          <= cfg_data;
      endcase
    end
  end

  // Front: accept and classify input words, queue the ones with work to do.
  kts_front #(.MAX_KEYS(MAX_KEYS), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .key_index       (key_index),
    .component_index (component_index),
    .key_time        (key_time),
    .key_value       (key_value),
    .request_time    (request_time),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // Back: write the key stores, run samples, drive the output register.
  kts_back #(.MAX_KEYS(MAX_KEYS), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_component (out_component),
    .out_value     (out_value),
    .used_time     (used_time),
    .status        (status),
    .last          (last)
  );

endmodule

// ===== test/kts_checker.sv =====
// Watches the sampler channels, predicts every output word and compares.
module kts_checker import kts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  key_index,
  input  logic [2:0]  component_index,
  input  logic [31:0] key_time,
  input  logic [31:0] key_value,
  input  logic [31:0] request_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_component,
  input  logic [31:0] out_value,
  input  logic [31:0] used_time,
  input  logic        status,
  input  logic        last,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  comp;
    logic [31:0] value;
    logic [31:0] used;
    logic        st;
    logic        lst;
  } sample_word_t;

  cfg_t         track_cfg;
  logic [31:0]  key_times_m [MAX_KEYS_DEF];
  logic [31:0]  key_vals_m  [MAX_KEYS_DEF][MAX_WIDTH_DEF];
  sample_word_t expected_words[$];

  assign pending = expected_words.size();

  // Append one predicted word at the tail of the queue.
  function automatic void queue_word(sample_word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic longint comp_val(int k, int c);
    return longint'($signed(key_vals_m[k][c]));
  endfunction

  function automatic longint blend_q16(longint a, longint b, longint f);
    return a + (((b - a) * f + 32768) >>> 16);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Map time, find keys, queue one word per component, or a status word.
  function automatic void predict_sample(logic [31:0] req);
    longint      start, stop, t, span, m, f, dot, bq, num;
    logic [63:0] ut, tl, tr, q, s, sq, r, mag;
    logic [64:0] acc;
    longint      vals[RESULT_LIMIT];
    bit          zero_range;
    int          width, n, lo, hi, mid, lft, rgt;
    sample_word_t w;
    start = track_cfg.range_start;
    stop  = (track_cfg.range_end == 0) ? longint'(track_cfg.clip_duration)
                                       : longint'(track_cfg.range_end);
    zero_range = track_cfg.clip_duration == 0 && track_cfg.range_start == 0 &&
                 track_cfg.range_end == 0;
    if ((stop <= start || stop > longint'(track_cfg.clip_duration)) && !zero_range) begin
      w = '{comp: 3'd0, value: 32'd0, used: 32'd0, st: 1'b1, lst: 1'b1};
      queue_word(w);
      return;
    end
    t = longint'($signed(req));
    if (track_cfg.playback_mode != PLAY_LOOP) begin
      if (t < start) t = start;
      if (t > stop) t = stop;
    end else if (zero_range) begin
      t = 0;
    end else begin
      span = stop - start;
      m = (t - start) % span;
      if (m < 0) m += span;
      t = m + start;
    end
    ut = t;
    if (track_cfg.channel_kind == CH_ROTATION) width = QUAT_COMPS;
    else if (track_cfg.channel_kind == CH_MORPH) begin
      width = (track_cfg.morph_weight_count == 0) ? 1 : track_cfg.morph_weight_count;
      if (width > MAX_WIDTH_DEF) width = MAX_WIDTH_DEF;
    end else width = VEC_COMPS;
    n = (track_cfg.key_count == 0) ? 1 : track_cfg.key_count;
    if (n > MAX_KEYS_DEF) n = MAX_KEYS_DEF;

    if (n == 1 || ut <= key_times_m[0]) begin
      for (int c = 0; c < width; c++) vals[c] = comp_val(0, c);
    end else if (ut >= key_times_m[n-1]) begin
      for (int c = 0; c < width; c++) vals[c] = comp_val(n - 1, c);
    end else begin
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (key_times_m[mid] <= ut) lo = mid + 1;
        else hi = mid;
      end
      rgt = lo;
      if (rgt < 1) rgt = 1;
      if (rgt > n - 1) rgt = n - 1;
      lft = rgt - 1;
      if (track_cfg.interpolation_mode == INTERP_STEP) begin
        for (int c = 0; c < width; c++) vals[c] = comp_val(lft, c);
      end else begin
        tl = key_times_m[lft];
        tr = key_times_m[rgt];
        f = 0;
        if (tr > tl && ut > tl) begin
          q = ((ut - tl) << 16) / (tr - tl);
          f = (q > 64'd65536) ? 65536 : longint'(q);
        end
        if (track_cfg.channel_kind != CH_ROTATION) begin
          for (int c = 0; c < width; c++)
            vals[c] = clip32(blend_q16(comp_val(lft, c), comp_val(rgt, c), f));
        end else begin
          // Take the shorter arc, then normalize by the integer root.
          dot = 0;
          s = '0;
          for (int c = 0; c < 4; c++)
            dot += (comp_val(lft, c) * comp_val(rgt, c)) >>> 2;
          for (int c = 0; c < 4; c++) begin
            bq = comp_val(rgt, c);
            if (dot < 0) bq = -bq;
            vals[c] = blend_q16(comp_val(lft, c), bq, f);
            sq = vals[c] * vals[c];
            acc = {1'b0, s} + {1'b0, sq};
            s = acc[64] ? '1 : acc[63:0];
          end
          r = int_sqrt(s);
          for (int c = 0; c < 4; c++) begin
            if (r == 0) begin
              vals[c] = 0;
            end else begin
              num = vals[c] * 65536;
              mag = (num < 0) ? -num : num;
              q = (mag + r / 2) / r;
              vals[c] = clip32((num < 0) ? -longint'(q) : longint'(q));
            end
          end
        end
      end
    end
    for (int c = 0; c < width; c++) begin
      w = '{comp: c[2:0], value: vals[c][31:0], used: ut[31:0], st: 1'b0,
            lst: (c == width - 1)};
      queue_word(w);
    end
  endfunction

  always @(posedge clk) begin
    sample_word_t e;
    if (rst) begin
      track_cfg <= '{channel_kind: 2'd0, morph_weight_count: 4'd1,
                     interpolation_mode: 1'b1, key_count: 9'd1, playback_mode: 1'b0,
                     clip_duration: 32'd0, range_start: 32'd0, range_end: 32'd0};
      errors <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CHANNEL_KIND:  track_cfg.channel_kind       = cfg_data[1:0];
          REG_MORPH_COUNT:   track_cfg.morph_weight_count = cfg_data[3:0];
          REG_INTERP_MODE:   track_cfg.interpolation_mode = cfg_data[0];
          REG_KEY_COUNT:     track_cfg.key_count          = cfg_data[8:0];
          REG_PLAYBACK_MODE: track_cfg.playback_mode      = cfg_data[0];
          REG_CLIP_DURATION: track_cfg.clip_duration      = cfg_data;
          REG_RANGE_START:   track_cfg.range_start        = cfg_data;
          REG_RANGE_END:     track_cfg.range_end          = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (kind)
          KIND_TIME:   key_times_m[key_index] = key_time;
          KIND_VALUE:  key_vals_m[key_index][component_index] = key_value;
          KIND_SAMPLE: predict_sample(request_time);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word comp=%0d value=%h used=%h status=%b last=%b",
                   $time, out_component, out_value, used_time, status, last);
          errors <= errors + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.comp !== out_component || e.value !== out_value || e.used !== used_time ||
              e.st !== status || e.lst !== last) begin
            $display("%0t: mismatch expected comp=%0d value=%h used=%h status=%b last=%b",
                     $time, e.comp, e.value, e.used, e.st, e.lst);
            $display("%0t:          actual   comp=%0d value=%h used=%h status=%b last=%b",
                     $time, out_component, out_value, used_time, status, last);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Stimulus, reset, watchdog and verdict for the keyframe track sampler.
module tb_top;
  import kts_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 400;
  localparam int HOLD_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [7:0]  key_index = '0;
  logic [2:0]  component_index = '0;
  logic [31:0] key_time = '0;
  logic [31:0] key_value = '0;
  logic [31:0] request_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_component;
  logic [31:0] out_value;
  logic [31:0] used_time;
  logic        status;
  logic        last;
  int          errors;
  int          pending;

  // Shared knobs: calm turns off idling on both sides, hold_out asks the
  // receiver for one long stall.
  bit          calm = 1'b0;
  bit          hold_out = 1'b0;
  int          idle_cycles = 0;

  logic [31:0] track_times[MAX_KEYS_DEF];

  always #5 clk = ~clk;

  keyframe_track_sampler_unit i_dut (.*);

  kts_checker i_checker (.*);

  // Drop the whole run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: draw a stall per word, take the one long stall on request.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offer one word and hold it until taken, then idle for a drawn gap.
  task automatic send_word(logic [1:0] k, logic [7:0] ki, logic [2:0] ci,
                           logic [31:0] kt, logic [31:0] kv, logic [31:0] rt);
    int gap;
    in_valid        <= 1'b1;
    kind            <= k;
    key_index       <= ki;
    component_index <= ci;
    key_time        <= kt;
    key_value       <= kv;
    request_time    <= rt;
    do @(posedge clk); while (!in_ready);
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for the block to drain, then write all eight registers.
  task automatic program_track(logic [1:0] ch, logic [3:0] morph, logic interp,
                               logic [8:0] nkeys, logic play, logic [31:0] clip,
                               logic [31:0] rs, logic [31:0] re);
    logic [31:0] vals[8];
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    vals = '{{30'd0, ch}, {28'd0, morph}, {31'd0, interp}, {23'd0, nkeys},
             {31'd0, play}, clip, rs, re};
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Load key times (rising, with repeats) and component values.
  task automatic load_keys(int nkeys, int comps, logic [31:0] base, int step_max);
    logic [32:0] tacc;
    logic [31:0] v;
    tacc = {1'b0, base};
    for (int k = 0; k < nkeys; k++) begin
      if (k > 0 && $urandom_range(0, 5) != 0)
        tacc = tacc + 33'($urandom_range(1, step_max));
      if (tacc[32]) tacc = 33'h0_FFFF_FFFF;
      track_times[k] = tacc[31:0];
      send_word(KIND_TIME, k[7:0], 3'd0, tacc[31:0], $urandom, $urandom);
      for (int c = 0; c < comps; c++) begin
        v = ($urandom_range(0, 1) == 0) ? $urandom : 32'($signed($urandom_range(0, 131072)) - 65536);
        send_word(KIND_VALUE, k[7:0], c[2:0], $urandom, v, $urandom);
      end
      // Unused kind: the block drops it.
      if ($urandom_range(0, 15) == 0)
        send_word(KIND_UNUSED, 8'($urandom), 3'($urandom), $urandom, $urandom, $urandom);
    end
  endtask

  // Pick a request time near the range, on a key, at an extreme, or anywhere.
  function automatic logic [31:0] pick_time(int nkeys, logic [31:0] lo, logic [31:0] hi);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return track_times[$urandom_range(0, nkeys - 1)];
      2: return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return lo + 32'($urandom_range(0, 32'(hi - lo)));
    endcase
  endfunction

  task automatic random_phase(bit big, bit stall);
    logic [1:0]  ch;
    logic [3:0]  morph;
    logic [8:0]  nkeys;
    int          loaded, comps, step_max, nsamples;
    logic [31:0] clip, rs, re, lo, hi;
    ch    = 2'($urandom_range(0, 3));
    morph = 4'($urandom_range(0, 15));
    nkeys = big ? 9'($urandom_range(24, 40)) : 9'($urandom_range(0, 6));
    loaded = (nkeys == 0) ? 1 : (nkeys > 256 ? 256 : nkeys);
    comps = (ch == CH_MORPH) ? ((morph == 0) ? 1 : (morph > 8 ? 8 : morph))
          : (ch == CH_ROTATION ? 4 : 3);
    step_max = ($urandom_range(0, 2) == 0) ? 16 : (($urandom_range(0, 1) == 0) ? 65536 : 1 << 24);
    calm = ($urandom_range(0, 3) == 0);
    program_track(ch, morph, 1'($urandom_range(0, 1)), nkeys, 1'($urandom_range(0, 1)),
                  32'd0, 32'd0, 32'd0);
    load_keys(loaded, comps, $urandom_range(0, 1 << 20), step_max);
    // Range around the keys; sometimes invalid, sometimes the all-zero default.
    clip = track_times[loaded - 1] + $urandom_range(1, 1 << 16);
    rs = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 32'(track_times[0])));
    re = $urandom_range(0, 2) ? 32'd0 : clip - $urandom_range(0, 100);
    case ($urandom_range(0, 9))
      0: begin clip = 0; rs = 0; re = 0; end
      1: re = rs;
      2: re = clip + 1;
      3: begin clip = 32'hFFFF_FFFF; re = 0; end
      default: ;
    endcase
    program_track(ch, morph, 1'($urandom_range(0, 1)), nkeys, 1'($urandom_range(0, 1)),
                  clip, rs, re);
    lo = (rs > 32'h1000_0000) ? rs - 32'h1000_0000 : 32'd0;
    hi = clip + 32'h0001_0000;
    nsamples = $urandom_range(12, 30);
    // Stall the receiver while the requests keep coming, so the block backs up.
    if (stall) hold_out = 1'b1;
    for (int i = 0; i < nsamples; i++)
      send_word(KIND_SAMPLE, 8'($urandom), 3'($urandom), $urandom, $urandom,
                pick_time(loaded, lo, hi));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings (one key, all-zero range), request extremes.
    calm = 1'b1;
    track_times[0] = 32'd0;
    send_word(KIND_TIME, 8'd0, 3'd0, 32'd0, '0, '0);
    for (int c = 0; c < 8; c++)
      send_word(KIND_VALUE, 8'd0, c[2:0], '0, (c[0] ? 32'h8000_0000 : 32'h7FFF_FFFF), '0);
    send_word(KIND_SAMPLE, '0, '0, '0, '0, 32'h8000_0000);
    send_word(KIND_SAMPLE, '0, '0, '0, '0, 32'h7FFF_FFFF);
    // Loop over all-zero range, then invalid ranges.
    program_track(CH_MORPH, 4'd8, INTERP_LINEAR, 9'd1, PLAY_LOOP, 32'd0, 32'd0, 32'd0);
    send_word(KIND_SAMPLE, '0, '0, '0, '0, 32'h1234_5678);
    program_track(CH_TRANSLATION, 4'd0, INTERP_STEP, 9'd0, PLAY_CLAMP,
                  32'd100, 32'd100, 32'd0);
    send_word(KIND_SAMPLE, '0, '0, '0, '0, 32'd5);
    program_track(CH_SCALE, 4'd15, INTERP_LINEAR, 9'd1, PLAY_CLAMP,
                  32'd100, 32'd0, 32'd101);
    send_word(KIND_SAMPLE, '0, '0, '0, '0, 32'd5);
    // Rotation with opposite hemispheres and equal key times.
    program_track(CH_ROTATION, 4'd1, INTERP_LINEAR, 9'd3, PLAY_LOOP,
                  32'hFFFF_FFFF, 32'd0, 32'd0);
    track_times[0] = 32'h0001_0000;
    track_times[1] = 32'h0002_0000;
    track_times[2] = 32'h0002_0000;
    for (int k = 0; k < 3; k++) begin
      send_word(KIND_TIME, k[7:0], '0, track_times[k], '0, '0);
      for (int c = 0; c < 4; c++)
        send_word(KIND_VALUE, k[7:0], c[2:0], '0,
                  (k == 1) ? 32'hFFFF_0000 : 32'h0001_0000, '0);
    end
    send_word(KIND_SAMPLE, '0, '0, '0, '0, 32'h0001_8000);
    send_word(KIND_SAMPLE, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_word(KIND_SAMPLE, '0, '0, '0, '0, 32'h0002_0000);

    // Random phases; one with a longer key table, one with a long stall.
    for (int p = 0; p < 8; p++)
      random_phase(p == 6, p == 3);

    in_valid <= 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/kts_pkg.sv
hdl/kts_ram.sv
hdl/kts_div.sv
hdl/kts_isqrt.sv
hdl/kts_front.sv
hdl/kts_back.sv
hdl/keyframe_track_sampler_unit.sv
test/kts_checker.sv
test/tb_top.sv
